>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DTYP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("dtyp assertion failed");
`define DTYP_ASSERT_NEVER(lbl, clk, rstn, prop) \
  `DTYP_ASSERT(lbl, clk, rstn, !(prop))
`else
`define DTYP_ASSERT(lbl, clk, rstn, prop)
`define DTYP_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

>>> rtl/dtyp_pkg.sv
`default_nettype none
package dtyp_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF     = 16;
  localparam int unsigned GUARD             = 24;
  localparam int unsigned ZK_SHIFT          = 30 - GUARD;
  localparam int unsigned VEC_W             = 60;
  localparam int unsigned COMP_W            = 32;
  localparam int unsigned OUT_W             = 26;
  localparam int unsigned Q16_W             = 27;
  localparam int unsigned K_W               = 31;
  localparam int unsigned ANG_EXTRA         = 10;
  localparam int unsigned PROD_W            = 64;

  localparam logic [63:0] PI_Q30       = 64'hC90FDAA2;
  localparam logic [63:0] PI_OVER4_Q62 = 64'h3243F6A8885A308D;

  localparam logic signed [Q16_W-1:0] Q16_360 = 27'sd23592960;
  localparam logic signed [Q16_W-1:0] Q16_270 = 27'sd17694720;
  localparam logic signed [Q16_W-1:0] Q16_90  = 27'sd5898240;
  localparam logic signed [Q16_W-1:0] Q16_M90 = -27'sd5898240;

  typedef struct packed {
    logic zero;   // x and y both zero
    logic zpos;   // z greater than zero
  } flags_t;

  // Shift-subtract division, used only for elaboration-time tables.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in degrees with fb fraction bits.
  function automatic logic [63:0] atan_deg(input int unsigned i, input int unsigned fb);
    logic [63:0] rad;
    logic [63:0] p;
    logic [63:0] k;
    logic [63:0] q;
    logic [63:0] k26;
    logic [63:0] deg;
    rad = '0;
    p   = '0;
    k   = '0;
    if (i > 61) return '0;
    if (i == 0) begin
      rad = PI_OVER4_Q62;
    end else begin
      p = 64'd1 << (62 - i);
      for (int n = 0; n < 64; n++) begin
        if (p != 0) begin
          q = udiv64(p, 2 * k + 1);
          if (!k[0]) rad = rad + q;
          else       rad = rad - q;
          p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
          k = k + 1;
        end
      end
    end
    rad = (rad + (64'd1 << 29)) >> 30;
    k26 = udiv64((64'd180 << 56) + PI_Q30 / 2, PI_Q30);
    deg = rad * k26;
    deg = (deg + (64'd1 << (57 - fb))) >> (58 - fb);
    return deg;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int n = 0; n < 32; n++) begin
      if (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // CORDIC gain in Q30.
  function automatic logic [K_W-1:0] gain_k(input int unsigned stages);
    logic [63:0] ksq;
    ksq = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      ksq = ksq + ((2 * i < 64) ? (ksq >> (2 * i)) : 64'd0);
    end
    return K_W'(isqrt64(ksq));
  endfunction

endpackage
`default_nettype wire

>>> rtl/dtyp_pre.sv
`default_nettype none
module dtyp_pre #(
  parameter int unsigned CORDIC_STAGES = dtyp_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned FRAC_BITS     = dtyp_pkg::FRAC_BITS_DEF,
  parameter int unsigned ANG_W         = FRAC_BITS + dtyp_pkg::ANG_EXTRA
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  adv_i,
  input  wire logic                                  valid_i,
  input  wire logic signed [dtyp_pkg::COMP_W-1:0]    x_i,
  input  wire logic signed [dtyp_pkg::COMP_W-1:0]    y_i,
  input  wire logic signed [dtyp_pkg::COMP_W-1:0]    z_i,
  output logic                                       valid_o,
  output logic signed [dtyp_pkg::VEC_W-1:0]          x_o,
  output logic signed [dtyp_pkg::VEC_W-1:0]          y_o,
  output logic signed [dtyp_pkg::VEC_W-1:0]          zk_o,
  output logic signed [ANG_W-1:0]                    base_o,
  output dtyp_pkg::flags_t                           flags_o
);

  localparam int unsigned EXT_W = dtyp_pkg::VEC_W - dtyp_pkg::COMP_W;
  localparam logic [dtyp_pkg::K_W-1:0] K = dtyp_pkg::gain_k(CORDIC_STAGES);
  localparam logic signed [dtyp_pkg::COMP_W-1:0] K_S = {1'b0, K};
  localparam logic signed [ANG_W-1:0] BASE_P = ANG_W'(64'd180 << FRAC_BITS);
  localparam logic signed [ANG_W-1:0] BASE_N = -BASE_P;

  logic                                    valid_q;
  logic signed [dtyp_pkg::VEC_W-1:0]       x_d, x_q, y_d, y_q, xs, ys;
  logic signed [dtyp_pkg::PROD_W-1:0]      prod_d, prod_q, zk_full;
  logic signed [ANG_W-1:0]                 base_d, base_q;
  dtyp_pkg::flags_t                        flags_d, flags_q;

  always_comb begin
    xs = {{EXT_W{x_i[dtyp_pkg::COMP_W-1]}}, x_i} <<< dtyp_pkg::GUARD;
    ys = {{EXT_W{y_i[dtyp_pkg::COMP_W-1]}}, y_i} <<< dtyp_pkg::GUARD;
    flags_d.zero = (x_i == '0) && (y_i == '0);
    flags_d.zpos = !z_i[dtyp_pkg::COMP_W-1] && (z_i != '0);
    prod_d = z_i * K_S;
    if (x_i[dtyp_pkg::COMP_W-1]) begin
      // turn the vector by 180 degrees into the right half plane
      x_d    = -xs;
      y_d    = -ys;
      base_d = y_i[dtyp_pkg::COMP_W-1] ? BASE_N : BASE_P;
    end else begin
      x_d    = xs;
      y_d    = ys;
      base_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      x_q     <= x_d;
      y_q     <= y_d;
      prod_q  <= prod_d;
      base_q  <= base_d;
      flags_q <= flags_d;
    end
  end

  assign zk_full = prod_q >>> dtyp_pkg::ZK_SHIFT;
  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign zk_o    = zk_full[dtyp_pkg::VEC_W-1:0];
  assign base_o  = base_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

>>> rtl/dtyp_cordic_stage.sv
`default_nettype none
module dtyp_cordic_stage #(
  parameter int unsigned             ANG_W  = dtyp_pkg::FRAC_BITS_DEF + dtyp_pkg::ANG_EXTRA,
  parameter int unsigned             SHIFT  = 0,
  parameter logic signed [ANG_W-1:0] ATAN   = '0,
  parameter int unsigned             SIDE_W = 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           adv_i,
  input  wire logic                           valid_i,
  input  wire logic signed [dtyp_pkg::VEC_W-1:0] x_i,
  input  wire logic signed [dtyp_pkg::VEC_W-1:0] y_i,
  input  wire logic signed [ANG_W-1:0]        acc_i,
  input  wire logic [SIDE_W-1:0]              side_i,
  output logic                                valid_o,
  output logic signed [dtyp_pkg::VEC_W-1:0]   x_o,
  output logic signed [dtyp_pkg::VEC_W-1:0]   y_o,
  output logic signed [ANG_W-1:0]             acc_o,
  output logic [SIDE_W-1:0]                   side_o
);

  logic                              valid_q;
  logic signed [dtyp_pkg::VEC_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ANG_W-1:0]           acc_d, acc_q;
  logic [SIDE_W-1:0]                 side_q;

  always_comb begin
    dx = x_i >>> SHIFT;
    dy = y_i >>> SHIFT;
    // rotate toward the x axis
    if (!y_i[dtyp_pkg::VEC_W-1]) begin
      x_d   = x_i + dy;
      y_d   = y_i - dx;
      acc_d = acc_i + ATAN;
    end else begin
      x_d   = x_i - dy;
      y_d   = y_i + dx;
      acc_d = acc_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

>>> rtl/dtyp_q16.sv
`default_nettype none
module dtyp_q16 #(
  parameter int unsigned DW        = dtyp_pkg::FRAC_BITS_DEF + dtyp_pkg::ANG_EXTRA,
  parameter int unsigned FRAC_BITS = dtyp_pkg::FRAC_BITS_DEF
) (
  input  wire logic signed [DW-1:0]              v_i,
  output logic signed [dtyp_pkg::Q16_W-1:0]      q_o
);

  if (FRAC_BITS > 16) begin : g_round
    localparam int unsigned S = FRAC_BITS - 16;
    logic signed [DW:0] r;
    logic signed [DW:0] rs;
    // round half up, then drop the extra fraction bits
    assign r  = $signed({v_i[DW-1], v_i}) + $signed((DW + 1)'(1) << (S - 1));
    assign rs = r >>> S;
    assign q_o = rs[dtyp_pkg::Q16_W-1:0];
  end else if (FRAC_BITS < 16) begin : g_widen
    logic signed [dtyp_pkg::Q16_W-1:0] e;
    assign e   = dtyp_pkg::Q16_W'(v_i);
    assign q_o = e <<< (16 - FRAC_BITS);
  end else begin : g_same
    assign q_o = dtyp_pkg::Q16_W'(v_i);
  end

endmodule
`default_nettype wire

>>> rtl/dtyp_out.sv
`default_nettype none
`include "assert_macros.svh"
module dtyp_out #(
  parameter int unsigned FRAC_BITS = dtyp_pkg::FRAC_BITS_DEF,
  parameter int unsigned ANG_W     = FRAC_BITS + dtyp_pkg::ANG_EXTRA
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        signed_mode_i,
  input  wire logic                        valid_i,
  input  wire logic signed [ANG_W-1:0]     yaw_acc_i,
  input  wire logic signed [ANG_W-1:0]     pitch_acc_i,
  input  wire dtyp_pkg::flags_t            flags_i,
  input  wire logic                        m_tready_i,
  output logic                             m_valid_o,
  output logic [2*dtyp_pkg::OUT_W-1:0]     m_data_o,
  output logic                             adv_o
);

  localparam int unsigned DW = 2 * dtyp_pkg::OUT_W;

  logic signed [ANG_W:0]               pitch_neg;
  logic signed [dtyp_pkg::Q16_W-1:0]   yaw_q16, pitch_q16, yaw_w, pitch_w;
  logic [DW-1:0]                       res;
  logic                                m_valid_q, skid_valid_q, take, in_fire;
  logic [DW-1:0]                       m_data_q, skid_data_q;

  assign pitch_neg = -$signed({pitch_acc_i[ANG_W-1], pitch_acc_i});

  dtyp_q16 #(.DW(ANG_W), .FRAC_BITS(FRAC_BITS)) u_yaw_q16 (
    .v_i(yaw_acc_i),
    .q_o(yaw_q16)
  );

  dtyp_q16 #(.DW(ANG_W + 1), .FRAC_BITS(FRAC_BITS)) u_pitch_q16 (
    .v_i(pitch_neg),
    .q_o(pitch_q16)
  );

  always_comb begin
    yaw_w   = yaw_q16;
    pitch_w = pitch_q16;
    if (flags_i.zero) begin
      yaw_w = '0;
      if (flags_i.zpos) pitch_w = signed_mode_i ? dtyp_pkg::Q16_M90 : dtyp_pkg::Q16_270;
      else              pitch_w = dtyp_pkg::Q16_90;
    end else if (!signed_mode_i) begin
      if (yaw_w[dtyp_pkg::Q16_W-1])   yaw_w   = yaw_w + dtyp_pkg::Q16_360;
      if (pitch_w[dtyp_pkg::Q16_W-1]) pitch_w = pitch_w + dtyp_pkg::Q16_360;
    end
    res = {yaw_w[dtyp_pkg::OUT_W-1:0], pitch_w[dtyp_pkg::OUT_W-1:0]};
  end

  assign adv_o   = !skid_valid_q;
  assign take    = m_valid_q && m_tready_i;
  assign in_fire = valid_i && adv_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q    <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      if (m_valid_q && !take) skid_valid_q <= 1'b1;
      else                    m_valid_q    <= 1'b1;
    end else if (take) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) m_data_q <= skid_data_q;
    end else if (in_fire) begin
      if (m_valid_q && !take) skid_data_q <= res;
      else                    m_data_q    <= res;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  `DTYP_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_valid_q |-> m_valid_q)
  `DTYP_ASSERT(a_skid_fill, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(m_valid_q && !m_tready_i))
  `DTYP_ASSERT(a_skid_drain, clk_i, rst_ni, skid_valid_q && m_tready_i |=> !skid_valid_q && m_valid_q)

endmodule
`default_nettype wire

>>> rtl/direction_to_yaw_pitch_core.sv
`default_nettype none
// A request passes the input register, the yaw and pitch stages and the output register.
// Throughput: one request per clock unless stalled; every CORDIC iteration is registered.
// A two-entry output (result register plus skid) takes one more result while one waits.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets signed_mode to 0.
module direction_to_yaw_pitch_core #(
  parameter int unsigned CORDIC_STAGES = dtyp_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned FRAC_BITS     = dtyp_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: bit 0 = signed_mode
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  // input requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // dir_x[31:0], dir_y[63:32], dir_z[95:64]
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata    // pitch_deg[25:0], yaw_deg[51:26], zero[55:52]
);

  localparam int unsigned ANG_W  = FRAC_BITS + dtyp_pkg::ANG_EXTRA;
  localparam int unsigned FL_W   = $bits(dtyp_pkg::flags_t);
  localparam int unsigned S1_W   = dtyp_pkg::VEC_W + FL_W;
  localparam int unsigned S2_W   = ANG_W + FL_W;
  localparam int unsigned CW     = dtyp_pkg::COMP_W;
  localparam int unsigned RES_W  = 2 * dtyp_pkg::OUT_W;

  logic signed_mode_q;
  logic adv;

  // hold the mode; write it only while the block is idle (the block does not enforce this)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      signed_mode_q <= cfg_wdata_i;
    end
  end

  // yaw pass: vector (x, y) rotated onto the x axis, angle starts at the half-plane base
  logic                              v1   [CORDIC_STAGES+1];
  logic signed [dtyp_pkg::VEC_W-1:0] x1   [CORDIC_STAGES+1];
  logic signed [dtyp_pkg::VEC_W-1:0] y1   [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]           a1   [CORDIC_STAGES+1];
  logic [S1_W-1:0]                   s1   [CORDIC_STAGES+1];
  logic signed [dtyp_pkg::VEC_W-1:0] zk0;
  dtyp_pkg::flags_t                  fl0;

  // pitch pass: vector (h, z*K) with h the scaled horizontal length
  logic                              v2   [CORDIC_STAGES+1];
  logic signed [dtyp_pkg::VEC_W-1:0] x2   [CORDIC_STAGES+1];
  logic signed [dtyp_pkg::VEC_W-1:0] y2   [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]           a2   [CORDIC_STAGES+1];
  logic [S2_W-1:0]                   s2   [CORDIC_STAGES+1];

  dtyp_pkg::flags_t                  fl_end;
  logic signed [ANG_W-1:0]           yaw_end;
  logic [RES_W-1:0]                  res_data;

  dtyp_pre #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS    (FRAC_BITS),
    .ANG_W        (ANG_W)
  ) u_pre (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(s_axis_tvalid),
    .x_i    ($signed(s_axis_tdata[CW-1:0])),
    .y_i    ($signed(s_axis_tdata[2*CW-1:CW])),
    .z_i    ($signed(s_axis_tdata[3*CW-1:2*CW])),
    .valid_o(v1[0]),
    .x_o    (x1[0]),
    .y_o    (y1[0]),
    .zk_o   (zk0),
    .base_o (a1[0]),
    .flags_o(fl0)
  );

  assign s1[0] = {fl0, zk0};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_yaw
    dtyp_cordic_stage #(
      .ANG_W (ANG_W),
      .SHIFT (i),
      .ATAN  (ANG_W'(dtyp_pkg::atan_deg(i, FRAC_BITS))),
      .SIDE_W(S1_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(v1[i]),
      .x_i    (x1[i]),
      .y_i    (y1[i]),
      .acc_i  (a1[i]),
      .side_i (s1[i]),
      .valid_o(v1[i+1]),
      .x_o    (x1[i+1]),
      .y_o    (y1[i+1]),
      .acc_o  (a1[i+1]),
      .side_o (s1[i+1])
    );
  end

  // hand over: h from the yaw pass, scaled z from the side band, yaw angle rides along
  assign v2[0] = v1[CORDIC_STAGES];
  assign x2[0] = x1[CORDIC_STAGES];
  assign y2[0] = $signed(s1[CORDIC_STAGES][dtyp_pkg::VEC_W-1:0]);
  assign a2[0] = '0;
  assign s2[0] = {s1[CORDIC_STAGES][S1_W-1:dtyp_pkg::VEC_W], a1[CORDIC_STAGES]};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pitch
    dtyp_cordic_stage #(
      .ANG_W (ANG_W),
      .SHIFT (i),
      .ATAN  (ANG_W'(dtyp_pkg::atan_deg(i, FRAC_BITS))),
      .SIDE_W(S2_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(v2[i]),
      .x_i    (x2[i]),
      .y_i    (y2[i]),
      .acc_i  (a2[i]),
      .side_i (s2[i]),
      .valid_o(v2[i+1]),
      .x_o    (x2[i+1]),
      .y_o    (y2[i+1]),
      .acc_o  (a2[i+1]),
      .side_o (s2[i+1])
    );
  end

  assign fl_end  = s2[CORDIC_STAGES][S2_W-1:ANG_W];
  assign yaw_end = $signed(s2[CORDIC_STAGES][ANG_W-1:0]);

  // format, wrap in unsigned mode, and drive the output register with skid
  dtyp_out #(
    .FRAC_BITS(FRAC_BITS),
    .ANG_W    (ANG_W)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .signed_mode_i(signed_mode_q),
    .valid_i      (v2[CORDIC_STAGES]),
    .yaw_acc_i    (yaw_end),
    .pitch_acc_i  (a2[CORDIC_STAGES]),
    .flags_i      (fl_end),
    .m_tready_i   (m_axis_tready),
    .m_valid_o    (m_axis_tvalid),
    .m_data_o     (res_data),
    .adv_o        (adv)
  );

  assign s_axis_tready = adv;
  assign m_axis_tdata  = {4'b0000, res_data};

endmodule
`default_nettype wire
